@@ design/axis_homing_supervisor_top_macros.svh @@
// Assertion macros for the homing supervisor top level.
`ifndef AXIS_HOMING_SUPERVISOR_TOP_MACROS_SVH
`define AXIS_HOMING_SUPERVISOR_TOP_MACROS_SVH

// Checked only while out of reset.
`define AHS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Checked at every edge, reset included.
`define AHS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) (expr)) else $error(msg);

`endif

@@ design/ahs_pkg.sv @@
// Types, codes and helpers for the homing supervisor.
package ahs_pkg;

    localparam int unsigned TICK_MS_DEF         = 5;
    localparam int unsigned PROGRESS_MARGIN_DEF = 5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SANE_LOW        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SANE_HIGH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIMEOUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT   = 3'd7;

    // Phase codes for the result channel (the step logic never produces PHASE_WAIT)
    localparam logic [2:0] PHASE_INIT  = 3'd0;
    localparam logic [2:0] PHASE_WAIT  = 3'd1;
    localparam logic [2:0] PHASE_SEEK  = 3'd2;
    localparam logic [2:0] PHASE_READY = 3'd3;
    localparam logic [2:0] PHASE_FAULT = 3'd4;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_SEEK  = 4'b0010,
        ST_READY = 4'b0100,
        ST_FAULT = 4'b1000
    } phase_state_t;

    typedef struct packed {
        logic        sample_valid;
        logic [15:0] sample_angle;
        logic        start_accepted;
    } in_item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       start_move;
        logic       move_positive;
        logic       stop_motor;
        logic       zero_position;
    } out_item_t;

    typedef struct packed {
        logic [15:0] reference_angle;
        logic [15:0] tolerance;
        logic [15:0] sane_low;
        logic [15:0] sane_high;
        logic [15:0] wait_timeout_ms;
        logic [15:0] move_timeout_ms;
        logic [15:0] loss_timeout_ms;
        logic [15:0] stall_timeout_ms;
    } cfg_t;

    typedef struct packed {
        phase_state_t phase;
        logic [15:0]  move_time;
        logic [15:0]  loss_time;
        logic [15:0]  stall_time;
        logic [15:0]  best_error;
    } sup_state_t;

    function automatic logic [2:0] phase_code(input phase_state_t st);
        logic [2:0] code;
        code = PHASE_INIT;
        unique case (st)
            ST_INIT:  code = PHASE_INIT;
            ST_SEEK:  code = PHASE_SEEK;
            ST_READY: code = PHASE_READY;
            ST_FAULT: code = PHASE_FAULT;
            default:  code = PHASE_FAULT;
        endcase
        return code;
    endfunction

endpackage

@@ design/ahs_cfg_regs.sv @@
// Configuration register file with reset values.
module ahs_cfg_regs
    import ahs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_REFERENCE_ANGLE: cfg_next.reference_angle  = wr_data;
                REG_TOLERANCE:       cfg_next.tolerance        = wr_data;
                REG_SANE_LOW:        cfg_next.sane_low         = wr_data;
                REG_SANE_HIGH:       cfg_next.sane_high        = wr_data;
                REG_WAIT_TIMEOUT:    cfg_next.wait_timeout_ms  = wr_data;
                REG_MOVE_TIMEOUT:    cfg_next.move_timeout_ms  = wr_data;
                REG_LOSS_TIMEOUT:    cfg_next.loss_timeout_ms  = wr_data;
                REG_STALL_TIMEOUT:   cfg_next.stall_timeout_ms = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reference_angle  <= 16'd18000;
            cfg_reg.tolerance        <= 16'd50;
            cfg_reg.sane_low         <= 16'd0;
            cfg_reg.sane_high        <= 16'd36000;
            cfg_reg.wait_timeout_ms  <= 16'd1000;
            cfg_reg.move_timeout_ms  <= 16'd10000;
            cfg_reg.loss_timeout_ms  <= 16'd200;
            cfg_reg.stall_timeout_ms <= 16'd2000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ahs_step.sv @@
// Per-tick supervisor decision: next state and result from one sample.
module ahs_step
    import ahs_pkg::*;
#(
    parameter int unsigned TICK_MS         = TICK_MS_DEF,
    parameter int unsigned PROGRESS_MARGIN = PROGRESS_MARGIN_DEF
) (
    input  sup_state_t cur,
    input  in_item_t   item,
    input  cfg_t       cfg,
    output sup_state_t nxt,
    output out_item_t  res
);

    localparam logic [16:0] TICK_INC = 17'(TICK_MS);
    localparam logic [16:0] MARGIN   = 17'(PROGRESS_MARGIN);

    logic [16:0] move_sum, loss_sum, stall_sum, err_sum;
    logic [15:0] move_inc, loss_inc, stall_inc;
    logic [15:0] err;
    logic        sane, within_tol, progress, below_ref;

    always_comb begin
        move_sum  = {1'b0, cur.move_time} + TICK_INC;
        loss_sum  = {1'b0, cur.loss_time} + TICK_INC;
        stall_sum = {1'b0, cur.stall_time} + TICK_INC;
        // saturating tick counters
        move_inc  = move_sum[16]  ? 16'hFFFF : move_sum[15:0];
        loss_inc  = loss_sum[16]  ? 16'hFFFF : loss_sum[15:0];
        stall_inc = stall_sum[16] ? 16'hFFFF : stall_sum[15:0];

        below_ref  = item.sample_angle < cfg.reference_angle;
        err        = below_ref ? (cfg.reference_angle - item.sample_angle)
                               : (item.sample_angle - cfg.reference_angle);
        sane       = (item.sample_angle >= cfg.sane_low) &&
                     (item.sample_angle <= cfg.sane_high);
        within_tol = err <= cfg.tolerance;
        err_sum    = {1'b0, err} + MARGIN;
        progress   = err_sum < {1'b0, cur.best_error};
    end

    always_comb begin
        nxt = cur;
        res = '0;
        unique case (cur.phase)
            ST_INIT: begin
                nxt.move_time = move_inc;
                if (!item.sample_valid) begin
                    if (move_inc >= cfg.wait_timeout_ms) begin
                        res.stop_motor = 1'b1;
                        nxt.phase      = ST_FAULT;
                    end
                end else if (!sane) begin
                    res.stop_motor = 1'b1;
                    nxt.phase      = ST_FAULT;
                end else if (within_tol) begin
                    res.stop_motor    = 1'b1;
                    res.zero_position = 1'b1;
                    nxt.phase         = ST_READY;
                end else begin
                    res.start_move    = 1'b1;
                    res.move_positive = below_ref;
                    if (!item.start_accepted) begin
                        // refused start: command and stop in the same tick
                        res.stop_motor = 1'b1;
                        nxt.phase      = ST_FAULT;
                    end else begin
                        nxt.phase      = ST_SEEK;
                        nxt.move_time  = '0;
                        nxt.loss_time  = '0;
                        nxt.stall_time = '0;
                        nxt.best_error = err;
                    end
                end
            end
            ST_SEEK: begin
                nxt.move_time = move_inc;
                if (move_inc >= cfg.move_timeout_ms) begin
                    res.stop_motor = 1'b1;
                    nxt.phase      = ST_FAULT;
                end else if (!item.sample_valid) begin
                    nxt.loss_time = loss_inc;
                    if (loss_inc >= cfg.loss_timeout_ms) begin
                        res.stop_motor = 1'b1;
                        nxt.phase      = ST_FAULT;
                    end
                end else begin
                    nxt.loss_time = '0;
                    if (!sane) begin
                        res.stop_motor = 1'b1;
                        nxt.phase      = ST_FAULT;
                    end else if (within_tol) begin
                        res.stop_motor    = 1'b1;
                        res.zero_position = 1'b1;
                        nxt.phase         = ST_READY;
                    end else if (progress) begin
                        nxt.best_error = err;
                        nxt.stall_time = '0;
                    end else begin
                        nxt.stall_time = stall_inc;
                        if (stall_inc >= cfg.stall_timeout_ms) begin
                            res.stop_motor = 1'b1;
                            nxt.phase      = ST_FAULT;
                        end
                    end
                end
            end
            ST_READY, ST_FAULT: begin
                nxt = cur;
            end
            default: begin
                nxt = cur;
            end
        endcase
        res.phase = phase_code(nxt.phase);
    end

endmodule

@@ design/axis_homing_supervisor_top.sv @@
// Homing supervisor top level: channel registers, supervisor state, configuration.
//
// One input transaction per control tick carries sample_valid, sample_angle and
// start_accepted; each produces exactly one result transaction with phase,
// start_move, move_positive, stop_motor and zero_position.
// Configuration registers are written over the cfg channel (cfg_index,
// cfg_data); cfg_ready is always high. Write only while no transaction is
// in flight.
// A result passes through the input register, then the result register.
// Throughput: one transaction per cycle while the receiver takes results;
// the state update between the two registers is combinational.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; further input waits on s_ready.
// Reset (aresetn low, synchronous) empties both registers, returns the
// phase to init with all timers and best error at zero, and restores the
// register defaults. Ready and fault are held until the next reset.
module axis_homing_supervisor_top
    import ahs_pkg::*;
#(
    parameter int unsigned TICK_MS         = TICK_MS_DEF,
    parameter int unsigned PROGRESS_MARGIN = PROGRESS_MARGIN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "axis_homing_supervisor_top_macros.svh"

    cfg_t       cfg;
    in_item_t   in_data_reg;
    logic       in_vld_reg, in_vld_next;
    out_item_t  out_data_reg;
    logic       out_vld_reg, out_vld_next;
    sup_state_t state_reg, state_next;
    out_item_t  step_res;
    logic       in_take, advance;

    assign cfg_ready = 1'b1;

    ahs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ahs_step #(
        .TICK_MS         (TICK_MS),
        .PROGRESS_MARGIN (PROGRESS_MARGIN)
    ) u_step (
        .cur  (state_reg),
        .item (in_data_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // the held item is processed when the result register can take it
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
            state_reg.phase      <= ST_INIT;
            state_reg.move_time  <= '0;
            state_reg.loss_time  <= '0;
            state_reg.stall_time <= '0;
            state_reg.best_error <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    `AHS_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (!out_vld_reg && !in_vld_reg), "registers not empty after reset")
    `AHS_ASSERT(a_ready_sticky, state_reg.phase == ST_READY |=> state_reg.phase == ST_READY, "left ready phase")
    `AHS_ASSERT(a_fault_sticky, state_reg.phase == ST_FAULT |=> state_reg.phase == ST_FAULT, "left fault phase")
    `AHS_ASSERT(a_result_phase, advance |=> out_data_reg.phase == phase_code(state_reg.phase), "result phase disagrees with state")
    `AHS_ASSERT(a_zero_implies_stop, (out_vld_reg && out_data_reg.zero_position) |-> (out_data_reg.stop_motor && out_data_reg.phase == PHASE_READY), "zero without finish")

endmodule

@@ tb/axis_homing_supervisor_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the homing supervisor: one homing run per reset, random idling.
module axis_homing_supervisor_top_tb;
    import ahs_pkg::*;

    // Tracks the supervisor tick by tick and checks every status transaction in order.
    class homing_checker;
        logic [15:0] reg_file [8];
        logic [2:0]  ph;
        int unsigned elapsed_ms, loss_ms, stall_ms, best_err;
        out_item_t   status_due [$];
        int          errors, ticks, checked, progress_hits, loss_ticks;

        function new();
            reg_file[REG_REFERENCE_ANGLE] = 16'd18000;
            reg_file[REG_TOLERANCE]       = 16'd50;
            reg_file[REG_SANE_LOW]        = 16'd0;
            reg_file[REG_SANE_HIGH]       = 16'd36000;
            reg_file[REG_WAIT_TIMEOUT]    = 16'd1000;
            reg_file[REG_MOVE_TIMEOUT]    = 16'd10000;
            reg_file[REG_LOSS_TIMEOUT]    = 16'd200;
            reg_file[REG_STALL_TIMEOUT]   = 16'd2000;
            ph = PHASE_INIT;
            elapsed_ms = 0;
            loss_ms = 0;
            stall_ms = 0;
            best_err = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            reg_file[idx] = val;
        endfunction

        // timers saturate at 16 bits
        function int unsigned bump(int unsigned t);
            return (t + TICK_MS_DEF > 32'hFFFF) ? 32'hFFFF : t + TICK_MS_DEF;
        endfunction

        function bit in_window(int unsigned a);
            return a >= reg_file[REG_SANE_LOW] && a <= reg_file[REG_SANE_HIGH];
        endfunction

        function int unsigned ref_err(int unsigned a);
            int unsigned r;
            r = reg_file[REG_REFERENCE_ANGLE];
            return (a >= r) ? a - r : r - a;
        endfunction

        function void take_tick(in_item_t it);
            out_item_t   st;
            int unsigned a, e;
            st = '0;
            a = it.sample_angle;
            e = ref_err(a);
            ticks++;
            case (ph)
                PHASE_INIT, PHASE_WAIT: begin
                    elapsed_ms = bump(elapsed_ms);
                    if (!it.sample_valid) begin
                        if (elapsed_ms >= reg_file[REG_WAIT_TIMEOUT]) begin
                            st.stop_motor = 1'b1;
                            ph = PHASE_FAULT;
                        end
                    end else if (!in_window(a)) begin
                        st.stop_motor = 1'b1;
                        ph = PHASE_FAULT;
                    end else if (e <= reg_file[REG_TOLERANCE]) begin
                        st.stop_motor = 1'b1;
                        st.zero_position = 1'b1;
                        ph = PHASE_READY;
                    end else begin
                        st.start_move = 1'b1;
                        st.move_positive = (a < reg_file[REG_REFERENCE_ANGLE]);
                        if (!it.start_accepted) begin
                            // refused start still commands the stop
                            st.stop_motor = 1'b1;
                            ph = PHASE_FAULT;
                        end else begin
                            ph = PHASE_SEEK;
                            elapsed_ms = 0;
                            loss_ms = 0;
                            stall_ms = 0;
                            best_err = e;
                        end
                    end
                end
                PHASE_SEEK: begin
                    elapsed_ms = bump(elapsed_ms);
                    if (elapsed_ms >= reg_file[REG_MOVE_TIMEOUT]) begin
                        st.stop_motor = 1'b1;
                        ph = PHASE_FAULT;
                    end else if (!it.sample_valid) begin
                        loss_ms = bump(loss_ms);
                        loss_ticks++;
                        if (loss_ms >= reg_file[REG_LOSS_TIMEOUT]) begin
                            st.stop_motor = 1'b1;
                            ph = PHASE_FAULT;
                        end
                    end else begin
                        loss_ms = 0;
                        if (!in_window(a)) begin
                            st.stop_motor = 1'b1;
                            ph = PHASE_FAULT;
                        end else if (e <= reg_file[REG_TOLERANCE]) begin
                            st.stop_motor = 1'b1;
                            st.zero_position = 1'b1;
                            ph = PHASE_READY;
                        end else if (e + PROGRESS_MARGIN_DEF < best_err) begin
                            best_err = e;
                            stall_ms = 0;
                            progress_hits++;
                        end else begin
                            stall_ms = bump(stall_ms);
                            if (stall_ms >= reg_file[REG_STALL_TIMEOUT]) begin
                                st.stop_motor = 1'b1;
                                ph = PHASE_FAULT;
                            end
                        end
                    end
                end
                default: ;  // ready, fault: inputs ignored
            endcase
            st.phase = ph;
            status_due.push_back(st);
        endfunction

        function void check_status(out_item_t got);
            out_item_t want;
            checked++;
            if (status_due.size() == 0) begin
                $error("status transaction with nothing expected: %h", got);
                errors++;
                return;
            end
            want = status_due.pop_front();
            if (got.phase !== want.phase) begin
                $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                errors++;
            end
            if (got.start_move !== want.start_move) begin
                $error("start_move: expected %0b, actual %0b", want.start_move, got.start_move);
                errors++;
            end
            if (got.move_positive !== want.move_positive) begin
                $error("move_positive: expected %0b, actual %0b",
                       want.move_positive, got.move_positive);
                errors++;
            end
            if (got.stop_motor !== want.stop_motor) begin
                $error("stop_motor: expected %0b, actual %0b", want.stop_motor, got.stop_motor);
                errors++;
            end
            if (got.zero_position !== want.zero_position) begin
                $error("zero_position: expected %0b, actual %0b",
                       want.zero_position, got.zero_position);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_REFERENCE_ANGLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    homing_checker chk;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;
    int hold_left       = 0;
    int ref_now, tol_now, lo_now, hi_now;
    int track_err;
    int cfg_writes      = 0;
    int sel;

    axis_homing_supervisor_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // generous bound on the whole run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check before noting so a spurious result never meets its own tick
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                chk.check_status(m_data);
            if (s_valid && s_ready)
                chk.take_tick(s_data);
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        do @(posedge aclk); while (!cfg_ready);
        chk.set_reg(idx, val[15:0]);
        case (idx)
            REG_REFERENCE_ANGLE: ref_now = val;
            REG_TOLERANCE:       tol_now = val;
            REG_SANE_LOW:        lo_now  = val;
            REG_SANE_HIGH:       hi_now  = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_tick(input logic valid, input int angle, input logic acc);
        in_item_t it;
        it.sample_valid   = valid;
        it.sample_angle   = angle[15:0];
        it.start_accepted = acc;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (chk.status_due.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (4) @(negedge aclk);
    endtask

    // pick a side of the reference that stays inside the sanity window
    function automatic int angle_at(input int err);
        bit up_ok, dn_ok;
        up_ok = (ref_now + err <= hi_now);
        dn_ok = (ref_now - err >= lo_now);
        if (up_ok && (!dn_ok || $urandom_range(1) == 1))
            return ref_now + err;
        return ref_now - err;
    endfunction

    // window always covers every error the trajectory can still produce
    task automatic configure_phase(input int idx);
        int rv, lo_lim, hi_lim;
        case (idx % 4)
            0: rv = 0;
            1: rv = 36000;
            2: rv = $urandom_range(36000, 0);
            default: rv = 18000;
        endcase
        lo_lim = rv - track_err - 400;
        if (lo_lim < 0) lo_lim = 0;
        hi_lim = rv + track_err + 400;
        if (hi_lim > 36000) hi_lim = 36000;
        write_reg(REG_REFERENCE_ANGLE, rv);
        write_reg(REG_TOLERANCE, (idx == 0) ? 0 : int'($urandom_range(100, 0)));
        write_reg(REG_SANE_LOW, $urandom_range(lo_lim, 0));
        write_reg(REG_SANE_HIGH, $urandom_range(36000, hi_lim));
        write_reg(REG_WAIT_TIMEOUT, $urandom_range(65535, 0));
        write_reg(REG_MOVE_TIMEOUT, $urandom_range(65535, 20000));
        write_reg(REG_LOSS_TIMEOUT, $urandom_range(65535, 500));
        write_reg(REG_STALL_TIMEOUT, $urandom_range(65535, 20000));
    endtask

    // mostly a noisy approach toward the reference, some lost samples, some stray angles
    task automatic seek_tick();
        int r, e, lim;
        r = $urandom_range(99);
        if (r < 78) begin
            track_err = track_err - int'($urandom_range(40, 0));
            if (track_err < 300) track_err = 300;
            e = track_err + int'($urandom_range(30, 0)) - 15;
            send_tick(1'b1, angle_at(e), $urandom_range(1));
        end else if (r < 90) begin
            send_tick(1'b0, $urandom_range(36000, 0), $urandom_range(1));
        end else begin
            lim = (track_err + 400 > 18000) ? 18000 : track_err + 400;
            e = $urandom_range(lim, tol_now + 1);
            send_tick(1'b1, angle_at(e), $urandom_range(1));
        end
    endtask

    initial begin
        int first_angle, guard;
        chk = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_idle(0);

        write_reg(REG_REFERENCE_ANGLE, 18000);
        write_reg(REG_TOLERANCE, 0);
        write_reg(REG_SANE_LOW, 0);
        write_reg(REG_SANE_HIGH, 36000);
        write_reg(REG_WAIT_TIMEOUT, 65535);
        write_reg(REG_MOVE_TIMEOUT, 65535);
        write_reg(REG_LOSS_TIMEOUT, 65535);
        write_reg(REG_STALL_TIMEOUT, 65535);

        // waiting in init with no sample
        send_tick(1'b0, 36000, 1'b0);
        send_tick(1'b0, 0, 1'b1);
        send_tick(1'b0, 32767, 1'b1);
        send_tick(1'b0, $urandom_range(36000, 0), 1'b0);
        drain_results();

        // zero wait timeout only bites on a tick without a sample
        write_reg(REG_WAIT_TIMEOUT, 0);
        first_angle = ($urandom_range(1) == 1) ? 0 : 36000;
        send_tick(1'b1, first_angle, 1'b1);
        send_tick(1'b1, 36000 - first_angle, 1'b0);  // same error, no progress
        send_tick(1'b0, 12345, 1'b1);
        send_tick(1'b0, 23456, 1'b0);
        send_tick(1'b1, 35000, 1'b1);                // progress
        send_tick(1'b1, 1005, 1'b0);                 // short of the margin by one
        send_tick(1'b1, 1006, 1'b1);                 // just past the margin
        send_tick(1'b1, 32767, 1'b0);
        send_tick(1'b1, 32768, 1'b1);
        track_err = 14700;

        for (int p = 0; p < 7; p++) begin
            drain_results();
            set_idle(p % 4);
            configure_phase(p);
            if (p == 4)
                hold_req = 300;  // fill the pipe while the sender keeps offering
            repeat (100) seek_tick();
        end

        drain_results();
        set_idle(3);
        sel = $urandom_range(5, 0);
        case (sel)
            0: begin
                write_reg(REG_TOLERANCE, 36000);
                send_tick(1'b1, angle_at(track_err), 1'b1);
            end
            1: send_tick(1'b1, ref_now, 1'b0);
            2: begin
                // inverted window rejects everything
                write_reg(REG_SANE_LOW, 36000);
                write_reg(REG_SANE_HIGH, 0);
                send_tick(1'b0, 0, 1'b0);
                send_tick(1'b1, angle_at(track_err), 1'b1);
            end
            3: begin
                write_reg(REG_MOVE_TIMEOUT, 0);
                send_tick(1'b1, angle_at(track_err), 1'b1);
            end
            4: begin
                write_reg(REG_LOSS_TIMEOUT, 50);
                repeat (12) send_tick(1'b0, $urandom_range(36000, 0), $urandom_range(1));
            end
            default: begin
                write_reg(REG_STALL_TIMEOUT, 25);
                repeat (8) send_tick(1'b1, angle_at(track_err + 50), $urandom_range(1));
            end
        endcase
        // terminal phase: everything ignored
        repeat (10) send_tick($urandom_range(1), $urandom_range(36000, 0), $urandom_range(1));

        guard = 0;
        s_valid <= 1'b0;
        while (chk.status_due.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (10) @(negedge aclk);
        if (chk.status_due.size() != 0) begin
            $error("%0d expected status transactions never arrived", chk.status_due.size());
            chk.errors++;
        end

        $display("Covered %0d ticks, %0d status checks, %0d progress updates, %0d lost samples,",
                 chk.ticks, chk.checked, chk.progress_hits, chk.loss_ticks);
        $display("%0d register writes; run ended in phase %0d via end case %0d.",
                 cfg_writes, chk.ph, sel);
        if (chk.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ahs_pkg.sv
design/ahs_cfg_regs.sv
design/ahs_step.sv
design/axis_homing_supervisor_top.sv
tb/axis_homing_supervisor_top_tb.sv
